// ===== sv/assert_macros.svh =====
// Assertion macros shared by the calendar date stepper modules.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define CDS_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Same-cycle implication.
`define CDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cds_pkg.sv =====
// Package for the calendar date stepper: constants, codes, types and
// calendar helper functions. No dependencies.
`default_nettype none

package cds_pkg;

  localparam int unsigned FIRST_YEAR  = 1900;
  localparam int unsigned COUNT_WIDTH = 12;

  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned DAYS_W  = 20;
  localparam int unsigned WEEK_W  = 3;
  localparam int unsigned CNT_IN_W = 12;

  localparam logic [YEAR_W-1:0]  YEAR_FIRST   = YEAR_W'(FIRST_YEAR);
  localparam logic [YEAR_W-1:0]  YEAR_LAST    = {YEAR_W{1'b1}};
  localparam logic [MONTH_W-1:0] MONTH_JAN    = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_FIRST    = DAY_W'(1);
  localparam logic [DAY_W-1:0]   DAY_DEC_LAST = DAY_W'(31);
  localparam logic [DAYS_W-1:0]  DAYS_PER_YEAR = DAYS_W'(365);
  localparam logic [WEEK_W-1:0]  WEEK_MONDAY  = WEEK_W'(1);
  localparam logic [WEEK_W-1:0]  WEEK_LAST    = WEEK_W'(6);

  localparam logic [1:0] M4_INIT   = 2'(FIRST_YEAR % 4);
  localparam logic [6:0] M100_INIT = 7'(FIRST_YEAR % 100);
  localparam logic [8:0] M400_INIT = 9'(FIRST_YEAR % 400);

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LOAD  = 2'd1,
    ST_SATURATED = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_YEARS,
    S_MONTHS,
    S_CHECK,
    S_STEP,
    S_DONE
  } state_e;

  // Year position inside the 4, 100 and 400 year leap cycles.
  typedef struct packed {
    logic [1:0] m4;
    logic [6:0] m100;
    logic [8:0] m400;
  } ypos_t;

  typedef struct packed {
    logic capture;
    logic year_step;
    logic month_step;
    logic commit;
    logic reject;
    logic step;
    logic saturate;
    logic publish;
  } cds_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  range_ok;
    logic  year_done;
    logic  month_done;
    logic  day_ok;
    logic  count_zero;
    logic  at_end;
  } cds_sts_t;

  localparam ypos_t YPOS_INIT = '{m4: M4_INIT, m100: M100_INIT, m400: M400_INIT};

  function automatic logic ypos_leap(input ypos_t p);
    return ((p.m4 == 2'd0) && (p.m100 != 7'd0)) || (p.m400 == 9'd0);
  endfunction

  function automatic ypos_t ypos_next(input ypos_t p);
    ypos_t r;
    r.m4   = p.m4 + 2'd1;
    r.m100 = (p.m100 == 7'd99)  ? 7'd0 : p.m100 + 7'd1;
    r.m400 = (p.m400 == 9'd399) ? 9'd0 : p.m400 + 9'd1;
    return r;
  endfunction

  function automatic ypos_t ypos_prev(input ypos_t p);
    ypos_t r;
    r.m4   = p.m4 - 2'd1;
    r.m100 = (p.m100 == 7'd0) ? 7'd99  : p.m100 - 7'd1;
    r.m400 = (p.m400 == 9'd0) ? 9'd399 : p.m400 - 9'd1;
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: r = DAY_W'(30);
      4'd2:                    r = leap ? DAY_W'(29) : DAY_W'(28);
      default:                 r = DAY_W'(31);
    endcase
    return r;
  endfunction

  function automatic logic [WEEK_W-1:0] add_mod7(input logic [WEEK_W-1:0] a,
                                                 input logic [WEEK_W-1:0] b);
    logic [WEEK_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) s = s - 4'd7;
    return s[WEEK_W-1:0];
  endfunction

  function automatic logic [WEEK_W-1:0] mod7_day(input logic [DAY_W-1:0] v);
    logic [DAY_W-1:0] r;
    r = v;
    for (int i = 0; i < 4; i++) begin
      if (r >= DAY_W'(7)) r = r - DAY_W'(7);
    end
    return r[WEEK_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/cds_chan_if.sv =====
// Request and response channel interfaces of the calendar date stepper.
// Depends on cds_pkg for field widths.
`default_nettype none

interface cds_req_if
  import cds_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [1:0]          mode;
  logic [MONTH_W-1:0]  load_month;
  logic [DAY_W-1:0]    load_day;
  logic [YEAR_W-1:0]   load_year;
  logic [CNT_IN_W-1:0] step_count;

  modport source (output valid, mode, load_month, load_day, load_year, step_count,
                  input ready);
  modport sink   (input valid, mode, load_month, load_day, load_year, step_count,
                  output ready);
endinterface

interface cds_rsp_if
  import cds_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [MONTH_W-1:0] month_out;
  logic [DAY_W-1:0]   day_out;
  logic [YEAR_W-1:0]  year_out;
  logic [WEEK_W-1:0]  weekday_out;
  logic [DAYS_W-1:0]  day_count;
  logic [1:0]         status;

  modport source (output valid, month_out, day_out, year_out, weekday_out, day_count,
                  status, input ready);
  modport sink   (input valid, month_out, day_out, year_out, weekday_out, day_count,
                  status, output ready);
endinterface

`default_nettype wire

// ===== sv/calendar_date_stepper_unit.sv =====
// Top level of the calendar date stepper: joins controller and datapath.
// Depends on cds_pkg, cds_chan_if, cds_ctrl and cds_dp.
//
//   channel  dir  handshake       payload
//   req_i    in   valid / ready   mode, load_month, load_day, load_year, step_count
//   rsp_o    out  valid / ready   month_out, day_out, year_out, weekday_out,
//                                 day_count, status
//
// A step request moves the date one day per cycle until its count runs out,
// stopping early when it saturates. A load walks the years and then the months
// from 1900-01; a load with a bad month or year skips the walk.
// Reset restores 1900-01-01, Monday, day count zero; it is taken at once.
// The response register frees the request side: a new request is taken while
// the previous response waits, and only the final transfer waits on rsp_o.
`default_nettype none

module calendar_date_stepper_unit
  import cds_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cds_req_if.sink     req_i,
  cds_rsp_if.source   rsp_o
);

  cds_cmd_t cmd;
  cds_sts_t sts;

  cds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cds_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (req_i.mode),
    .load_month_i (req_i.load_month),
    .load_day_i   (req_i.load_day),
    .load_year_i  (req_i.load_year),
    .step_count_i (req_i.step_count),
    .month_o      (rsp_o.month_out),
    .day_o        (rsp_o.day_out),
    .year_o       (rsp_o.year_out),
    .weekday_o    (rsp_o.weekday_out),
    .day_count_o  (rsp_o.day_count),
    .status_o     (rsp_o.status)
  );

endmodule

`default_nettype wire

// ===== sv/cds_dp.sv =====
// Datapath of the calendar date stepper: date state, load walk registers,
// single-day step logic and the response register. Depends on cds_pkg.
`default_nettype none
`include "assert_macros.svh"

module cds_dp
  import cds_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cds_cmd_t            cmd_i,
  output      cds_sts_t            sts_o,
  input  wire logic [1:0]          mode_i,
  input  wire logic [MONTH_W-1:0]  load_month_i,
  input  wire logic [DAY_W-1:0]    load_day_i,
  input  wire logic [YEAR_W-1:0]   load_year_i,
  input  wire logic [CNT_IN_W-1:0] step_count_i,
  output      logic [MONTH_W-1:0]  month_o,
  output      logic [DAY_W-1:0]    day_o,
  output      logic [YEAR_W-1:0]   year_o,
  output      logic [WEEK_W-1:0]   weekday_o,
  output      logic [DAYS_W-1:0]   day_count_o,
  output      logic [1:0]          status_o
);

  mode_e                  mode_q;
  logic [MONTH_W-1:0]     lm_q;
  logic [DAY_W-1:0]       ld_q;
  logic [YEAR_W-1:0]      ly_q;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  logic [DAY_W-1:0]   cur_day_q, cur_day_d;
  logic [MONTH_W-1:0] cur_month_q, cur_month_d;
  logic [YEAR_W-1:0]  cur_year_q, cur_year_d;
  ypos_t              cur_ypos_q, cur_ypos_d;
  logic [DAYS_W-1:0]  elapsed_q, elapsed_d;
  logic [WEEK_W-1:0]  week_q, week_d;
  status_e            status_q, status_d;

  logic [YEAR_W-1:0]  w_year_q, w_year_d;
  ypos_t              w_ypos_q, w_ypos_d;
  logic [MONTH_W-1:0] w_month_q, w_month_d;
  logic [DAYS_W-1:0]  w_total_q, w_total_d;
  logic [WEEK_W-1:0]  w_week_q, w_week_d;

  logic               leap_w, leap_cur;
  logic [DAY_W-1:0]   w_dim, load_dim, cur_dim, prev_dim;
  logic [DAY_W-1:0]   ld_m1;
  logic               at_end_up, at_end_dn;

  assign leap_w   = ypos_leap(w_ypos_q);
  assign leap_cur = ypos_leap(cur_ypos_q);
  assign w_dim    = month_len(w_month_q, leap_w);
  assign load_dim = month_len(lm_q, leap_w);
  assign cur_dim  = month_len(cur_month_q, leap_cur);
  assign prev_dim = month_len(cur_month_q - MONTH_W'(1), leap_cur);
  assign ld_m1    = ld_q - DAY_W'(1);

  assign at_end_up = (cur_year_q == YEAR_LAST) && (cur_month_q == MONTH_DEC) &&
                     (cur_day_q == DAY_DEC_LAST);
  assign at_end_dn = (cur_year_q <= YEAR_FIRST) && (cur_month_q == MONTH_JAN) &&
                     (cur_day_q == DAY_FIRST);

  always_comb begin
    sts_o.mode       = mode_q;
    sts_o.range_ok   = (lm_q >= MONTH_JAN) && (lm_q <= MONTH_DEC) && (ly_q >= YEAR_FIRST);
    sts_o.year_done  = (w_year_q == ly_q);
    sts_o.month_done = (w_month_q == lm_q);
    sts_o.day_ok     = (ld_q != '0) && (ld_q <= load_dim);
    sts_o.count_zero = (cnt_q == '0);
    sts_o.at_end     = (mode_q == MODE_DOWN) ? at_end_dn : at_end_up;
  end

  // Load walk: years first, then months of the target year.
  always_comb begin
    w_year_d  = w_year_q;
    w_ypos_d  = w_ypos_q;
    w_month_d = w_month_q;
    w_total_d = w_total_q;
    w_week_d  = w_week_q;
    if (cmd_i.capture) begin
      w_year_d  = YEAR_FIRST;
      w_ypos_d  = YPOS_INIT;
      w_month_d = MONTH_JAN;
      w_total_d = '0;
      w_week_d  = WEEK_MONDAY;
    end else if (cmd_i.year_step) begin
      w_year_d  = w_year_q + YEAR_W'(1);
      w_ypos_d  = ypos_next(w_ypos_q);
      w_total_d = w_total_q + DAYS_PER_YEAR + DAYS_W'(leap_w);
      w_week_d  = add_mod7(w_week_q, leap_w ? WEEK_W'(2) : WEEK_W'(1));
    end else if (cmd_i.month_step) begin
      w_month_d = w_month_q + MONTH_W'(1);
      w_total_d = w_total_q + DAYS_W'(w_dim);
      w_week_d  = add_mod7(w_week_q, WEEK_W'(w_dim - DAY_W'(28)));
    end
  end

  // Date state, status and step count: capture, commit a load or move one day.
  always_comb begin
    cur_day_d   = cur_day_q;
    cur_month_d = cur_month_q;
    cur_year_d  = cur_year_q;
    cur_ypos_d  = cur_ypos_q;
    elapsed_d   = elapsed_q;
    week_d      = week_q;
    status_d    = status_q;
    cnt_d       = cnt_q;
    if (cmd_i.capture) begin
      status_d = ST_OK;
      cnt_d    = step_count_i[COUNT_WIDTH-1:0];
    end
    if (cmd_i.reject)   status_d = ST_BAD_LOAD;
    if (cmd_i.saturate) status_d = ST_SATURATED;
    if (cmd_i.commit) begin
      cur_day_d   = ld_q;
      cur_month_d = lm_q;
      cur_year_d  = ly_q;
      cur_ypos_d  = w_ypos_q;
      elapsed_d   = w_total_q + DAYS_W'(ld_m1);
      week_d      = add_mod7(w_week_q, mod7_day(ld_m1));
    end else if (cmd_i.step) begin
      cnt_d = cnt_q - COUNT_WIDTH'(1);
      if (mode_q == MODE_DOWN) begin
        elapsed_d = elapsed_q - DAYS_W'(1);
        week_d    = (week_q == '0) ? WEEK_LAST : week_q - WEEK_W'(1);
        if (cur_day_q > DAY_FIRST) begin
          cur_day_d = cur_day_q - DAY_W'(1);
        end else if (cur_month_q > MONTH_JAN) begin
          cur_month_d = cur_month_q - MONTH_W'(1);
          cur_day_d   = prev_dim;
        end else begin
          cur_month_d = MONTH_DEC;
          cur_day_d   = DAY_DEC_LAST;
          cur_year_d  = cur_year_q - YEAR_W'(1);
          cur_ypos_d  = ypos_prev(cur_ypos_q);
        end
      end else begin
        elapsed_d = elapsed_q + DAYS_W'(1);
        week_d    = (week_q == WEEK_LAST) ? '0 : week_q + WEEK_W'(1);
        if (cur_day_q < cur_dim) begin
          cur_day_d = cur_day_q + DAY_W'(1);
        end else if (cur_month_q < MONTH_DEC) begin
          cur_day_d   = DAY_FIRST;
          cur_month_d = cur_month_q + MONTH_W'(1);
        end else begin
          cur_day_d   = DAY_FIRST;
          cur_month_d = MONTH_JAN;
          cur_year_d  = cur_year_q + YEAR_W'(1);
          cur_ypos_d  = ypos_next(cur_ypos_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_day_q   <= DAY_FIRST;
      cur_month_q <= MONTH_JAN;
      cur_year_q  <= YEAR_FIRST;
      cur_ypos_q  <= YPOS_INIT;
      elapsed_q   <= '0;
      week_q      <= WEEK_MONDAY;
    end else begin
      cur_day_q   <= cur_day_d;
      cur_month_q <= cur_month_d;
      cur_year_q  <= cur_year_d;
      cur_ypos_q  <= cur_ypos_d;
      elapsed_q   <= elapsed_d;
      week_q      <= week_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_e'(mode_i);
      lm_q   <= load_month_i;
      ld_q   <= load_day_i;
      ly_q   <= load_year_i;
    end
    cnt_q     <= cnt_d;
    status_q  <= status_d;
    w_year_q  <= w_year_d;
    w_ypos_q  <= w_ypos_d;
    w_month_q <= w_month_d;
    w_total_q <= w_total_d;
    w_week_q  <= w_week_d;
    if (cmd_i.publish) begin
      month_o     <= cur_month_q;
      day_o       <= cur_day_q;
      year_o      <= cur_year_q;
      weekday_o   <= week_q;
      day_count_o <= elapsed_q;
      status_o    <= status_q;
    end
  end

  `CDS_ASSERT(a_month_range, (cur_month_q >= MONTH_JAN) && (cur_month_q <= MONTH_DEC), "month out of range")
  `CDS_ASSERT(a_day_range, (cur_day_q >= DAY_FIRST) && (cur_day_q <= cur_dim), "day out of range")
  `CDS_ASSERT(a_leap_track, cur_ypos_q.m4 == cur_year_q[1:0], "leap cycle position out of step")

endmodule

`default_nettype wire

// ===== sv/cds_ctrl.sv =====
// Controller of the calendar date stepper: sequences decode, load walk,
// day stepping and the response handshake. Depends on cds_pkg.
`default_nettype none
`include "assert_macros.svh"

module cds_ctrl
  import cds_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  output      logic     req_ready_o,
  output      logic     rsp_valid_o,
  input  wire logic     rsp_ready_i,
  input  wire cds_sts_t sts_i,
  output      cds_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || rsp_ready_i;
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (req_valid_i) state_d = S_DECODE;
      S_DECODE: begin
        unique case (sts_i.mode)
          MODE_LOAD: state_d = sts_i.range_ok ? S_YEARS : S_DONE;
          MODE_UP, MODE_DOWN: state_d = S_STEP;
          default: state_d = S_DONE;
        endcase
      end
      S_YEARS:  if (sts_i.year_done) state_d = S_MONTHS;
      S_MONTHS: if (sts_i.month_done) state_d = S_CHECK;
      S_CHECK:  state_d = S_DONE;
      S_STEP:   if (sts_i.count_zero || sts_i.at_end) state_d = S_DONE;
      S_DONE:   if (slot_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    req_ready_o = (state_q == S_IDLE);
    cmd_o.capture    = (state_q == S_IDLE) && req_valid_i;
    cmd_o.year_step  = (state_q == S_YEARS) && !sts_i.year_done;
    cmd_o.month_step = (state_q == S_MONTHS) && !sts_i.month_done;
    cmd_o.commit     = (state_q == S_CHECK) && sts_i.day_ok;
    cmd_o.reject     = ((state_q == S_CHECK) && !sts_i.day_ok) ||
                       ((state_q == S_DECODE) && (sts_i.mode == MODE_LOAD) &&
                        !sts_i.range_ok);
    cmd_o.step       = (state_q == S_STEP) && !sts_i.count_zero && !sts_i.at_end;
    cmd_o.saturate   = (state_q == S_STEP) && !sts_i.count_zero && sts_i.at_end;
    cmd_o.publish    = (state_q == S_DONE) && slot_free;
  end

  always_comb begin
    priority if (cmd_o.publish) out_valid_d = 1'b1;
    else if (rsp_ready_i)       out_valid_d = 1'b0;
    else                        out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `CDS_ASSERT_NXT(a_capture_decode, cmd_o.capture, state_q == S_DECODE, "request not decoded")
  `CDS_ASSERT_IMP(a_publish_free, cmd_o.publish, !out_valid_q || rsp_ready_i, "response overwritten")
  `CDS_ASSERT_IMP(a_walk_is_load, (state_q == S_YEARS) || (state_q == S_MONTHS), sts_i.mode == MODE_LOAD, "walk outside load")

endmodule

`default_nettype wire

// ===== tb/calendar_date_stepper_unit_test.sv =====
// Testbench for calendar_date_stepper_unit: random and directed load and step requests,
// checked field by field against a cycle-free calendar predictor held in a scoreboard.
// Depends on cds_pkg, cds_chan_if and the calendar_date_stepper_unit RTL.
`default_nettype none

module calendar_date_stepper_unit_test;
  import cds_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1950;
  localparam int unsigned CALM_TAIL       = 150;

  typedef struct {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [YEAR_W-1:0]  year;
    logic [WEEK_W-1:0]  weekday;
    logic [DAYS_W-1:0]  elapsed;
    logic [1:0]         status;
  } date_view_t;

  class calendar_tracker;
    bit [DAY_W-1:0]   day;
    bit [MONTH_W-1:0] month;
    bit [YEAR_W-1:0]  year;
    bit [DAYS_W-1:0]  elapsed;
    bit [WEEK_W-1:0]  weekday;
    date_view_t       pending_dates[$];
    int unsigned      failures;

    function new();
      day      = DAY_FIRST;
      month    = MONTH_JAN;
      year     = YEAR_FIRST;
      elapsed  = '0;
      weekday  = WEEK_MONDAY;
      failures = 0;
    endfunction

    static function bit leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    static function int unsigned days_in_month(int unsigned m, int unsigned y);
      case (m)
        4, 6, 9, 11: return 30;
        2:           return leap(y) ? 29 : 28;
        default:     return 31;
      endcase
    endfunction

    function bit advance_day();
      if (year == YEAR_LAST && month == MONTH_DEC && day == DAY_DEC_LAST) return 1'b0;
      if (day >= days_in_month(month, year)) begin
        day = DAY_FIRST;
        if (month == MONTH_DEC) begin
          month = MONTH_JAN;
          year  = year + 1'b1;
        end else begin
          month = month + 1'b1;
        end
      end else begin
        day = day + 1'b1;
      end
      elapsed = elapsed + 1'b1;
      weekday = (weekday == WEEK_LAST) ? '0 : weekday + 1'b1;
      return 1'b1;
    endfunction

    function bit retreat_day();
      if (year == YEAR_FIRST && month == MONTH_JAN && day == DAY_FIRST) return 1'b0;
      if (day > DAY_FIRST) begin
        day = day - 1'b1;
      end else begin
        if (month > MONTH_JAN) begin
          month = month - 1'b1;
        end else begin
          month = MONTH_DEC;
          year  = year - 1'b1;
        end
        day = DAY_W'(days_in_month(month, year));
      end
      elapsed = elapsed - 1'b1;
      weekday = (weekday == '0) ? WEEK_LAST : weekday - 1'b1;
      return 1'b1;
    endfunction

    function void note_request(mode_e m, bit [MONTH_W-1:0] lm, bit [DAY_W-1:0] ld,
                               bit [YEAR_W-1:0] ly, bit [CNT_IN_W-1:0] cnt);
      date_view_t  v;
      status_e     st;
      int unsigned total;
      int unsigned steps;
      st    = ST_OK;
      steps = cnt & ((1 << COUNT_WIDTH) - 1);
      case (m)
        MODE_LOAD: begin
          if (lm >= MONTH_JAN && lm <= MONTH_DEC && ly >= YEAR_FIRST &&
              ld >= DAY_FIRST && ld <= days_in_month(lm, ly)) begin
            total = 0;
            for (int unsigned y = FIRST_YEAR; y < ly; y++) total += leap(y) ? 366 : 365;
            for (int unsigned k = 1; k < lm; k++) total += days_in_month(k, ly);
            total   += ld - 1;
            day      = ld;
            month    = lm;
            year     = ly;
            elapsed  = DAYS_W'(total);
            weekday  = WEEK_W'((total + 1) % 7);
          end else begin
            st = ST_BAD_LOAD;
          end
        end
        MODE_UP: begin
          for (int unsigned i = 0; i < steps; i++) begin
            if (!advance_day()) begin
              st = ST_SATURATED;
              break;
            end
          end
        end
        MODE_DOWN: begin
          for (int unsigned i = 0; i < steps; i++) begin
            if (!retreat_day()) begin
              st = ST_SATURATED;
              break;
            end
          end
        end
        default: ;
      endcase
      v.month   = month;
      v.day     = day;
      v.year    = year;
      v.weekday = weekday;
      v.elapsed = elapsed;
      v.status  = st;
      pending_dates.push_back(v);
    endfunction

    function void check_response(date_view_t got);
      date_view_t want;
      if (pending_dates.size() == 0) begin
        $error("response with no request outstanding");
        failures++;
        return;
      end
      want = pending_dates.pop_front();
      if (got.month !== want.month) begin
        $error("month_out: expected %0d, got %0d", want.month, got.month);
        failures++;
      end
      if (got.day !== want.day) begin
        $error("day_out: expected %0d, got %0d", want.day, got.day);
        failures++;
      end
      if (got.year !== want.year) begin
        $error("year_out: expected %0d, got %0d", want.year, got.year);
        failures++;
      end
      if (got.weekday !== want.weekday) begin
        $error("weekday_out: expected %0d, got %0d", want.weekday, got.weekday);
        failures++;
      end
      if (got.elapsed !== want.elapsed) begin
        $error("day_count: expected %0d, got %0d", want.elapsed, got.elapsed);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;

  cds_req_if req_ch();
  cds_rsp_if rsp_ch();

  calendar_tracker tracker;

  calendar_date_stepper_unit dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_ch),
    .rsp_o (rsp_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Hold off the response side in random bursts.
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        rsp_ch.ready = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rsp_ch.ready = 1'b0;
        stall_left   = $urandom_range(1, 8) - 1;
      end else begin
        rsp_ch.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    date_view_t got;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got.month   = rsp_ch.month_out;
      got.day     = rsp_ch.day_out;
      got.year    = rsp_ch.year_out;
      got.weekday = rsp_ch.weekday_out;
      got.elapsed = rsp_ch.day_count;
      got.status  = rsp_ch.status;
      tracker.check_response(got);
    end
  end

  task automatic send_request(input mode_e m, input logic [MONTH_W-1:0] lm,
                              input logic [DAY_W-1:0] ld, input logic [YEAR_W-1:0] ly,
                              input logic [CNT_IN_W-1:0] cnt);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    req_ch.valid      = 1'b1;
    req_ch.mode       = m;
    req_ch.load_month = lm;
    req_ch.load_day   = ld;
    req_ch.load_year  = ly;
    req_ch.step_count = cnt;
    do @(posedge clk_i); while (!req_ch.ready);
    tracker.note_request(m, lm, ld, ly, cnt);
  endtask

  task automatic send_random_request();
    mode_e                m;
    logic [MONTH_W-1:0]   lm;
    logic [DAY_W-1:0]     ld;
    logic [YEAR_W-1:0]    ly;
    logic [CNT_IN_W-1:0]  cnt;
    int unsigned          pick;
    int unsigned          r;
    lm   = MONTH_W'($urandom);
    ld   = DAY_W'($urandom);
    ly   = YEAR_W'($urandom);
    cnt  = CNT_IN_W'($urandom);
    pick = $urandom_range(0, 99);
    r    = $urandom_range(0, 99);
    if (pick < 25) begin
      m = MODE_LOAD;
      if (r < 80) begin
        if (r < 52) ly = YEAR_W'($urandom_range(FIRST_YEAR, 2100));
        else if (r < 64) ly = YEAR_W'($urandom_range(4000, 4095));
        else ly = YEAR_W'($urandom_range(FIRST_YEAR, 4095));
        lm = MONTH_W'($urandom_range(1, 12));
        ld = DAY_W'($urandom_range(1, calendar_tracker::days_in_month(lm, ly)));
        if ($urandom_range(0, 9) == 0) begin
          ld = DAY_W'(calendar_tracker::days_in_month(lm, ly) + 1);
        end
      end
    end else begin
      if (pick < 61) m = MODE_UP;
      else if (pick < 97) m = MODE_DOWN;
      else m = MODE_NONE;
      if (r < 80) cnt = CNT_IN_W'($urandom_range(0, 40));
      else if (r < 95) cnt = CNT_IN_W'($urandom_range(0, 400));
    end
    send_request(m, lm, ld, ly, cnt);
  endtask

  initial begin
    tracker           = new();
    calm              = 1'b0;
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.mode       = MODE_NONE;
    req_ch.load_month = '0;
    req_ch.load_day   = '0;
    req_ch.load_year  = '0;
    req_ch.step_count = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(MODE_DOWN, 4'd0, 5'd0, 12'd0, 12'd1);
    send_request(MODE_UP, 4'd0, 5'd0, 12'd0, 12'd0);
    send_request(MODE_NONE, 4'd15, 5'd31, 12'd4095, 12'd4095);
    send_request(MODE_LOAD, 4'd2, 5'd29, 12'd2000, 12'd0);
    send_request(MODE_LOAD, 4'd2, 5'd29, 12'd1900, 12'd0);
    send_request(MODE_LOAD, 4'd2, 5'd29, 12'd2001, 12'd0);
    send_request(MODE_LOAD, 4'd0, 5'd1, 12'd2000, 12'd0);
    send_request(MODE_LOAD, 4'd13, 5'd1, 12'd2000, 12'd0);
    send_request(MODE_LOAD, 4'd15, 5'd31, 12'd4095, 12'd4095);
    send_request(MODE_LOAD, 4'd1, 5'd1, 12'd1899, 12'd0);
    send_request(MODE_LOAD, 4'd1, 5'd1, 12'd0, 12'd0);
    send_request(MODE_LOAD, 4'd5, 5'd0, 12'd1950, 12'd0);
    send_request(MODE_LOAD, 4'd4, 5'd31, 12'd1950, 12'd0);
    send_request(MODE_LOAD, 4'd12, 5'd31, 12'd4095, 12'd0);
    send_request(MODE_UP, 4'd0, 5'd0, 12'd0, 12'd1);
    send_request(MODE_DOWN, 4'd0, 5'd0, 12'd0, 12'd4095);
    send_request(MODE_LOAD, 4'd12, 5'd30, 12'd4095, 12'd0);
    send_request(MODE_UP, 4'd0, 5'd0, 12'd0, 12'd4095);
    send_request(MODE_LOAD, 4'd1, 5'd5, 12'd1900, 12'd0);
    send_request(MODE_DOWN, 4'd0, 5'd0, 12'd0, 12'd4095);
    send_request(MODE_UP, 4'd0, 5'd0, 12'd0, 12'd4095);
    send_request(MODE_LOAD, 4'd2, 5'd28, 12'd1900, 12'd0);
    send_request(MODE_UP, 4'd0, 5'd0, 12'd0, 12'd1);
    send_request(MODE_LOAD, 4'd3, 5'd1, 12'd2000, 12'd0);
    send_request(MODE_DOWN, 4'd0, 5'd0, 12'd0, 12'd1);

    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i >= RANDOM_REQUESTS - CALM_TAIL) calm = 1'b1;
      send_random_request();
    end

    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (tracker.pending_dates.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.failures == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+sv
sv/cds_pkg.sv
sv/cds_chan_if.sv
sv/cds_dp.sv
sv/cds_ctrl.sv
sv/calendar_date_stepper_unit.sv
tb/calendar_date_stepper_unit_test.sv
